// ----- hdl/bpg_pkg.sv -----
// Shared types, constants and the pattern table of the buzzer pattern generator.
`default_nettype none
package bpg_pkg;

	localparam int unsigned CYCLE_WIDTH = 32;

	localparam logic [3:0] NO_ALARM = 4'd15;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_ALARM = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		CODE_STOP          = 4'd0,
		CODE_STARTUP       = 4'd1,
		CODE_SETTING_DONE  = 4'd2,
		CODE_TIME_REACH    = 4'd3,
		CODE_ASSIST        = 4'd4,
		CODE_VOTE_CARD     = 4'd5,
		CODE_TAMPER_ACT    = 4'd6,
		CODE_TAMPER_DETECT = 4'd7,
		CODE_BATTERY_LOW   = 4'd8
	} alarm_code_t;

	typedef struct packed {
		logic       operation;
		logic [3:0] alarm_code;
		logic       tamper_detected;
	} item_t;

	typedef struct packed {
		logic buzzer_level;
		logic pattern_running;
	} result_t;

	typedef struct packed {
		logic [7:0]             on_ticks;
		logic [7:0]             period_ticks;
		logic [CYCLE_WIDTH-1:0] cycles;
		logic                   valid;
	} pattern_t;

	localparam logic [7:0] TAMPER_ON     = 8'd10;
	localparam logic [7:0] TAMPER_PERIOD = 8'd30;

	function automatic pattern_t pattern_lookup(input logic [3:0] code);
		pattern_t p;
		p = '0;
		case (code)
			CODE_STARTUP:       p = '{8'd5, 8'd6, CYCLE_WIDTH'(1), 1'b1};
			CODE_SETTING_DONE:  p = '{8'd10, 8'd20, CYCLE_WIDTH'(3), 1'b1};
			CODE_TIME_REACH:    p = '{8'd20, 8'd21, CYCLE_WIDTH'(1), 1'b1};
			CODE_ASSIST:        p = '{8'd10, 8'd20, CYCLE_WIDTH'(2), 1'b1};
			CODE_VOTE_CARD:     p = '{8'd5, 8'd6, CYCLE_WIDTH'(1), 1'b1};
			CODE_TAMPER_ACT:    p = '{8'd10, 8'd11, CYCLE_WIDTH'(1), 1'b1};
			CODE_TAMPER_DETECT: p = '{8'd10, 8'd11, CYCLE_WIDTH'(3), 1'b1};
			CODE_BATTERY_LOW:   p = '{8'd10, 8'd20, CYCLE_WIDTH'(3), 1'b1};
			default:            p = '0;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/bpg_request_if.sv -----
// Request channel carrying ticks and alarm requests into the generator.
`default_nettype none
interface bpg_request_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [3:0] alarm_code;
	logic       tamper_detected;

	modport source (output valid, output operation, output alarm_code,
		output tamper_detected, input ready);
	modport sink (input valid, input operation, input alarm_code,
		input tamper_detected, output ready);
endinterface
`default_nettype wire

// ----- hdl/bpg_status_if.sv -----
// Status channel carrying the buzzer level and running flag after each request.
`default_nettype none
interface bpg_status_if;
	logic valid;
	logic ready;
	logic buzzer_level;
	logic pattern_running;

	modport source (output valid, output buzzer_level, output pattern_running,
		input ready);
	modport sink (input valid, input buzzer_level, input pattern_running,
		output ready);
endinterface
`default_nettype wire

// ----- hdl/buzzer_pattern_generator_unit.sv -----
// Top level of the buzzer pattern generator: input register, state update, status register.
`default_nettype none
// Each request transaction is either one timer tick or one alarm request and
// yields exactly one status transaction with the buzzer level and running flag
// after that request. A request is captured in an input register; when the
// status side can advance, the pattern state is updated from it and the
// status lands in an output register together with it. One request is taken
// every cycle as long as the status side keeps up; a stalled status holds the
// input register, which then holds the request side.
module buzzer_pattern_generator_unit (
	input wire logic       clk,
	input wire logic       arst_n,
	bpg_request_if.sink    request,
	bpg_status_if.source   status
);
	import bpg_pkg::*;

	logic    item_valid_s1;
	item_t   item_s1;
	logic    status_valid_q;
	result_t status_q;
	result_t next_result;
	logic    advance;

	assign advance       = !status_valid_q || status.ready;
	assign request.ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (request.ready) begin
			item_valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.ready && request.valid) begin
			item_s1.operation       <= request.operation;
			item_s1.alarm_code      <= request.alarm_code;
			item_s1.tamper_detected <= request.tamper_detected;
		end
	end

	bpg_state_unit u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.update      (item_valid_s1 && advance),
		.item        (item_s1),
		.next_result (next_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_valid_q <= 1'b0;
		end else if (advance) begin
			status_valid_q <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_valid_s1) begin
			status_q <= next_result;
		end
	end

	assign status.valid           = status_valid_q;
	assign status.buzzer_level    = status_q.buzzer_level;
	assign status.pattern_running = status_q.pattern_running;

`ifndef NO_ASSERTIONS
	a_stall_holds_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 && !advance |=> item_valid_s1 && $stable(item_s1))
		else $error("queued request lost during a status stall");

	a_status_follows : assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 && advance |=> status_valid_q)
		else $error("processed request produced no status transaction");

	a_ready_when_free : assert property (@(posedge clk) disable iff (!arst_n)
		!item_valid_s1 |-> request.ready)
		else $error("empty input register refused a transaction");
`endif
endmodule
`default_nettype wire

// ----- hdl/bpg_state_unit.sv -----
// Pattern state registers and their combinational update for one tick or alarm.
`default_nettype none
module bpg_state_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            update,
	input  wire bpg_pkg::item_t  item,
	output bpg_pkg::result_t     next_result
);
	import bpg_pkg::*;

	logic                   active_q, active_d;
	logic                   ticking_q, ticking_d;
	logic [7:0]             phase_q, phase_d;
	logic [7:0]             on_q, on_d;
	logic [7:0]             period_q, period_d;
	logic [CYCLE_WIDTH-1:0] cycles_q, cycles_d;
	logic [3:0]             last_q, last_d;

	pattern_t               pat;
	logic [7:0]             phase_dec;
	logic [CYCLE_WIDTH-1:0] cycles_dec;

	always_comb begin
		pat        = pattern_lookup(item.alarm_code);
		phase_dec  = phase_q - 8'd1;
		cycles_dec = cycles_q - CYCLE_WIDTH'(1);

		active_d  = active_q;
		ticking_d = ticking_q;
		phase_d   = phase_q;
		on_d      = on_q;
		period_d  = period_q;
		cycles_d  = cycles_q;
		last_d    = last_q;

		if (item.operation == OP_TICK) begin
			if (ticking_q) begin
				if (cycles_q == '0) begin
					ticking_d = 1'b0;
					last_d    = NO_ALARM;
				end else if (phase_q != 8'd0) begin
					phase_d = phase_dec;
					if (phase_dec == 8'd0) begin
						if (active_q) begin
							active_d = 1'b0;
							phase_d  = period_q - on_q;
						end else begin
							cycles_d = cycles_dec;
							if (cycles_dec != '0) begin
								phase_d  = on_q;
								active_d = 1'b1;
							end
						end
					end
				end
			end
		end else begin
			if (item.alarm_code == CODE_STOP) begin
				ticking_d = 1'b0;
				last_d    = NO_ALARM;
				active_d  = 1'b0;
			end else if (item.alarm_code != last_q) begin
				if (!item.tamper_detected && pat.valid) begin
					active_d  = 1'b1;
					period_d  = pat.period_ticks;
					phase_d   = pat.on_ticks;
					on_d      = pat.on_ticks;
					cycles_d  = pat.cycles;
					ticking_d = 1'b1;
				end else if (item.tamper_detected
						&& item.alarm_code == CODE_TAMPER_DETECT) begin
					active_d  = 1'b1;
					period_d  = TAMPER_PERIOD;
					phase_d   = TAMPER_ON;
					on_d      = TAMPER_ON;
					cycles_d  = '1;
					ticking_d = 1'b1;
				end
				last_d = item.alarm_code;
			end
		end

		next_result.buzzer_level    = active_d;
		next_result.pattern_running = ticking_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			ticking_q <= 1'b0;
			phase_q   <= '0;
			on_q      <= '0;
			period_q  <= '0;
			cycles_q  <= '0;
			last_q    <= NO_ALARM;
		end else if (update) begin
			active_q  <= active_d;
			ticking_q <= ticking_d;
			phase_q   <= phase_d;
			on_q      <= on_d;
			period_q  <= period_d;
			cycles_q  <= cycles_d;
			last_q    <= last_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_stop_clears : assert property (@(posedge clk) disable iff (!arst_n)
		update && item.operation == OP_ALARM && item.alarm_code == CODE_STOP
		|=> !ticking_q && !active_q && last_q == NO_ALARM)
		else $error("stop request did not silence the buzzer");

	a_idle_tick : assert property (@(posedge clk) disable iff (!arst_n)
		update && item.operation == OP_TICK && !ticking_q
		|=> $stable(active_q) && $stable(cycles_q) && $stable(last_q))
		else $error("tick changed state while stopped");

	a_repeat_ignored : assert property (@(posedge clk) disable iff (!arst_n)
		update && item.operation == OP_ALARM && item.alarm_code != CODE_STOP
		&& item.alarm_code == last_q
		|=> $stable(active_q) && $stable(ticking_q) && $stable(cycles_q))
		else $error("repeated alarm changed the pattern");

	a_hold : assert property (@(posedge clk) disable iff (!arst_n)
		!update |=> $stable(ticking_q) && $stable(phase_q) && $stable(last_q))
		else $error("state changed without a transaction");
`endif
endmodule
`default_nettype wire

// ----- tb/buzzer_pattern_monitor.sv -----
// Checker that predicts every status transaction of the buzzer pattern generator and compares it.
module buzzer_pattern_monitor
	import bpg_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	bpg_request_if      request,
	bpg_status_if       status,
	output int unsigned errors,
	output int unsigned outstanding,
	output int unsigned checked,
	output int unsigned finished
);

	logic                   buzzer_on;
	logic                   running;
	logic [7:0]             phase_left;
	logic [7:0]             on_len;
	logic [7:0]             period_len;
	logic [CYCLE_WIDTH-1:0] cycles_left;
	logic [3:0]             last_code;

	result_t     expected_status_q[$];
	item_t       req;
	result_t     want;
	int unsigned mismatch_cnt;
	int unsigned checked_cnt;
	int unsigned finished_cnt;

	function automatic result_t advance_pattern(input item_t item);
		logic                   starts;
		logic [7:0]             new_on;
		logic [7:0]             new_period;
		logic [CYCLE_WIDTH-1:0] new_cycles;
		result_t                res;
		starts = 1'b1;
		new_on = '0;
		new_period = '0;
		new_cycles = '0;
		if (item.operation == OP_TICK) begin
			if (running) begin
				if (cycles_left == '0) begin
					running = 1'b0;
					last_code = NO_ALARM;
					finished_cnt++;
				end else if (phase_left != '0) begin
					phase_left = phase_left - 8'd1;
					if (phase_left == '0) begin
						if (buzzer_on) begin
							buzzer_on = 1'b0;
							phase_left = period_len - on_len;
						end else begin
							cycles_left = cycles_left - 1'b1;
							if (cycles_left != '0) begin
								phase_left = on_len;
								buzzer_on = 1'b1;
							end
						end
					end
				end
			end
		end else if (item.alarm_code == CODE_STOP) begin
			running = 1'b0;
			buzzer_on = 1'b0;
			last_code = NO_ALARM;
		end else if (item.alarm_code != last_code) begin
			if (item.tamper_detected) begin
				starts = (item.alarm_code == CODE_TAMPER_DETECT);
				new_on = TAMPER_ON;
				new_period = TAMPER_PERIOD;
				new_cycles = '1;
			end else begin
				case (item.alarm_code)
					CODE_STARTUP, CODE_VOTE_CARD: begin
						new_on = 8'd5;
						new_period = 8'd6;
						new_cycles = CYCLE_WIDTH'(1);
					end
					CODE_SETTING_DONE, CODE_BATTERY_LOW: begin
						new_on = 8'd10;
						new_period = 8'd20;
						new_cycles = CYCLE_WIDTH'(3);
					end
					CODE_TIME_REACH: begin
						new_on = 8'd20;
						new_period = 8'd21;
						new_cycles = CYCLE_WIDTH'(1);
					end
					CODE_ASSIST: begin
						new_on = 8'd10;
						new_period = 8'd20;
						new_cycles = CYCLE_WIDTH'(2);
					end
					CODE_TAMPER_ACT: begin
						new_on = 8'd10;
						new_period = 8'd11;
						new_cycles = CYCLE_WIDTH'(1);
					end
					CODE_TAMPER_DETECT: begin
						new_on = 8'd10;
						new_period = 8'd11;
						new_cycles = CYCLE_WIDTH'(3);
					end
					default: starts = 1'b0;
				endcase
			end
			if (starts) begin
				buzzer_on = 1'b1;
				running = 1'b1;
				on_len = new_on;
				period_len = new_period;
				phase_left = new_on;
				cycles_left = new_cycles;
			end
			last_code = item.alarm_code;
		end
		res.buzzer_level = buzzer_on;
		res.pattern_running = running;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buzzer_on = 1'b0;
			running = 1'b0;
			phase_left = '0;
			on_len = '0;
			period_len = '0;
			cycles_left = '0;
			last_code = NO_ALARM;
			expected_status_q.delete();
			mismatch_cnt = 0;
			checked_cnt = 0;
			finished_cnt = 0;
			errors <= 0;
			outstanding <= 0;
			checked <= 0;
			finished <= 0;
		end else begin
			if (status.valid && status.ready) begin
				if (expected_status_q.size() == 0) begin
					if (mismatch_cnt < 10)
						$display("[%0t] Unexpected status transaction: %s %0b %s %0b",
							$realtime, "buzzer", status.buzzer_level,
							"running", status.pattern_running);
					mismatch_cnt++;
				end else begin
					want = expected_status_q.pop_front();
					checked_cnt++;
					if (status.buzzer_level !== want.buzzer_level ||
							status.pattern_running !== want.pattern_running) begin
						if (mismatch_cnt < 10)
							$display("[%0t] Status mismatch: %s %0b %0b, %s %0b %0b",
								$realtime, "expected buzzer/running",
								want.buzzer_level, want.pattern_running,
								"got buzzer/running",
								status.buzzer_level, status.pattern_running);
						mismatch_cnt++;
					end
				end
			end
			if (request.valid && request.ready) begin
				req.operation = request.operation;
				req.alarm_code = request.alarm_code;
				req.tamper_detected = request.tamper_detected;
				expected_status_q.push_back(advance_pattern(req));
			end
			errors <= mismatch_cnt;
			outstanding <= expected_status_q.size();
			checked <= checked_cnt;
			finished <= finished_cnt;
		end
	end

endmodule

// ----- tb/buzzer_pattern_generator_unit_tb.sv -----
// Testbench top for the buzzer pattern generator: stimulus, receiver stalls and the verdict.
module buzzer_pattern_generator_unit_tb;
	import bpg_pkg::*;

	localparam logic [3:0] CODE_UNKNOWN_LOW  = 4'd9;
	localparam logic [3:0] CODE_UNKNOWN_HIGH = 4'd14;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PERIODIC
	} rx_mode_t;

	logic        clk;
	logic        arst_n;
	int unsigned errors;
	int unsigned outstanding;
	int unsigned checked;
	int unsigned finished;
	int unsigned ticks_sent = 0;
	int unsigned alarms_sent = 0;
	int unsigned burst_left = 0;
	int unsigned sequences = 0;
	rx_mode_t    rx_mode = RX_ALWAYS;
	int unsigned rx_mode_left = 0;
	int unsigned rx_phase = 0;

	bpg_request_if request();
	bpg_status_if  status();

	buzzer_pattern_generator_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.status  (status)
	);

	buzzer_pattern_monitor pattern_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.request     (request),
		.status      (status),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.finished    (finished)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_mode_left <= $urandom_range(64, 256);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		rx_phase <= (rx_phase == 6) ? 0 : rx_phase + 1;
		case (rx_mode)
			RX_ALWAYS: status.ready <= 1'b1;
			RX_RANDOM: status.ready <= ($urandom_range(0, 9) < 7);
			default:   status.ready <= (rx_phase > 2);
		endcase
	end

	task automatic send(input op_t op, input logic [3:0] code, input logic tamper);
		if (burst_left == 0) begin
			request.valid <= 1'b0;
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(10, 30)) @(posedge clk);
			else
				repeat ($urandom_range(1, 4)) @(posedge clk);
			if ($urandom_range(0, 7) == 0)
				burst_left = $urandom_range(60, 150);
			else
				burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		request.valid <= 1'b1;
		request.operation <= op;
		request.alarm_code <= code;
		request.tamper_detected <= tamper;
		@(posedge clk);
		while (!request.ready) @(posedge clk);
		if (op == OP_TICK)
			ticks_sent++;
		else
			alarms_sent++;
	endtask

	task automatic drain();
		request.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic run_pattern_sequence();
		logic [3:0]  code;
		logic        tamper;
		int unsigned tick_cnt;
		int unsigned pick;
		if ($urandom_range(0, 19) < 15)
			code = 4'($urandom_range(1, 8));
		else
			code = 4'($urandom);
		tamper = ($urandom_range(0, 5) == 0);
		send(OP_ALARM, code, tamper);
		if ($urandom_range(0, 3) == 0)
			tick_cnt = $urandom_range(0, 15);
		else
			tick_cnt = $urandom_range(20, 70);
		repeat (tick_cnt) begin
			pick = $urandom_range(0, 39);
			if (pick == 0)
				send(OP_ALARM, code, tamper);
			else if (pick == 1)
				send(OP_ALARM, 4'($urandom), 1'($urandom));
			else
				send(OP_TICK, 4'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		request.valid = 1'b0;
		request.operation = OP_TICK;
		request.alarm_code = CODE_STOP;
		request.tamper_detected = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(OP_TICK, NO_ALARM, 1'b1);
		send(OP_ALARM, CODE_STARTUP, 1'b0);
		send(OP_ALARM, CODE_STARTUP, 1'b0);
		repeat (7) send(OP_TICK, CODE_STOP, 1'b1);
		send(OP_ALARM, CODE_UNKNOWN_LOW, 1'b0);
		send(OP_ALARM, CODE_UNKNOWN_HIGH, 1'b1);
		send(OP_ALARM, NO_ALARM, 1'b0);
		send(OP_ALARM, CODE_TIME_REACH, 1'b1);
		send(OP_ALARM, CODE_TAMPER_DETECT, 1'b1);
		send(OP_TICK, CODE_BATTERY_LOW, 1'b0);
		send(OP_ALARM, CODE_SETTING_DONE, 1'b0);
		send(OP_ALARM, CODE_STOP, 1'b1);
		send(OP_ALARM, CODE_ASSIST, 1'b0);
		send(OP_ALARM, CODE_VOTE_CARD, 1'b0);
		send(OP_ALARM, CODE_TAMPER_ACT, 1'b0);
		send(OP_ALARM, CODE_TAMPER_DETECT, 1'b0);
		send(OP_ALARM, CODE_BATTERY_LOW, 1'b0);
		send(OP_ALARM, CODE_STOP, 1'b0);
		drain();

		while (ticks_sent + alarms_sent < 1125) begin
			run_pattern_sequence();
			sequences++;
			if (sequences % 9 == 0)
				drain();
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d ticks and %0d alarm requests in %0d random pattern sequences.",
			ticks_sent, alarms_sent, sequences);
		$display("Checked %0d status transactions; %0d patterns ran to their natural end.",
			checked, finished);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Run timed out waiting for status transactions.");
		$display("Simulation FAILED");
		$finish;
	end

endmodule
